[src/ccgp_pkg.sv]
// Shared types, codes and defaults for the case/control genotype percentage block.
// Used by the channel interfaces and every module; depends on nothing.
package ccgp_pkg;

  localparam int MAX_SAMPLES_DEF = 4096;
  localparam int QUEUE_DEPTH_DEF = 4;
  localparam int TAG_W           = 32;
  localparam int PCT_W           = 7;
  localparam int PAIRS           = 6;

  localparam logic [1:0] GRP_EXCLUDED = 2'd0;
  localparam logic [1:0] GRP_CASE     = 2'd1;

  localparam logic [2:0] GT_HOM_REF = 3'd0;
  localparam logic [2:0] GT_HOM_ALT = 3'd2;
  localparam logic [2:0] GT_MISSING = 3'd3;

  typedef enum logic [1:0] {
    ST_TALLY,
    ST_LOAD,
    ST_DIV,
    ST_OUT
  } state_t;

  // One classified genotype on its way from front to back.
  typedef struct packed {
    logic             counted;   // valid call in case or control
    logic             is_class;  // hom ref, het or hom alt
    logic [1:0]       cls;       // 0 hom ref, 1 het, 2 hom alt
    logic             grp_ctrl;  // 0 case, 1 control
    logic             last;
    logic [TAG_W-1:0] tag;
  } item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_stat_t;

endpackage

[src/ccgp_if.sv]
// Channel interfaces for genotype samples in and percentage results out.
// Depends on ccgp_pkg.
interface ccgp_in_if;
  import ccgp_pkg::*;
  logic       valid;
  logic       ready;
  logic [1:0] sample_group;
  logic [2:0] genotype_code;
  logic [TAG_W-1:0] site_tag;
  logic       last_of_site;

  modport source (output valid, sample_group, genotype_code, site_tag, last_of_site,
                  input ready);
  modport sink   (input valid, sample_group, genotype_code, site_tag, last_of_site,
                  output ready);
endinterface

interface ccgp_out_if;
  import ccgp_pkg::*;
  logic             valid;
  logic             ready;
  logic [TAG_W-1:0] result_site_tag;
  logic [PCT_W-1:0] case_hom_ref_pct;
  logic [PCT_W-1:0] control_hom_ref_pct;
  logic [PCT_W-1:0] case_het_pct;
  logic [PCT_W-1:0] control_het_pct;
  logic [PCT_W-1:0] case_hom_alt_pct;
  logic [PCT_W-1:0] control_hom_alt_pct;

  modport source (output valid, result_site_tag, case_hom_ref_pct, control_hom_ref_pct,
                  case_het_pct, control_het_pct, case_hom_alt_pct, control_hom_alt_pct,
                  input ready);
  modport sink   (input valid, result_site_tag, case_hom_ref_pct, control_hom_ref_pct,
                  case_het_pct, control_het_pct, case_hom_alt_pct, control_hom_alt_pct,
                  output ready);
endinterface

[src/case_control_genotype_percent.sv]
// Top level of the case/control genotype percentage block.
// Depends on ccgp_pkg, ccgp_if, ccgp_front, ccgp_fifo and ccgp_back.
//
//   channel   dir  handshake      payload
//   samples   in   valid/ready    sample_group, genotype_code, site_tag, last_of_site
//   results   out  valid/ready    result_site_tag, six floor percentages
//
// Flow: one sample transaction per cycle while a site is being tallied and the
// queue is not full. The last sample of a site holds the back end in the shared
// restoring divider (a load step plus seven quotient bits per percentage), then
// the result moves into the output register once that register is free.
// Reset: synchronous on rst; clears the queue, counters, sequencer and result valid.
// Stalls: the queue keeps taking samples while the back end divides or waits on
// results.ready; samples.ready drops only when the queue is full.
module case_control_genotype_percent
  import ccgp_pkg::*;
#(
  parameter int MAX_SAMPLES = MAX_SAMPLES_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  ccgp_in_if.sink    samples,
  ccgp_out_if.source results
);

  // classified item from front to queue, head of queue to back
  item_t       push_item;
  item_t       head;
  queue_stat_t qstat;
  logic        push;
  logic        pop;

  // Classify group and genotype; push while the queue has room.
  ccgp_front u_front (
    .samples (samples),
    .qstat   (qstat),
    .push    (push),
    .item    (push_item)
  );

  // Decouple intake from the divider so each side can stall alone.
  ccgp_fifo #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head      (head),
    .qstat     (qstat)
  );

  // Tally, divide on the last sample of a site, then present the result.
  ccgp_back #(
    .MAX_SAMPLES (MAX_SAMPLES)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .head    (head),
    .qstat   (qstat),
    .pop     (pop),
    .results (results)
  );

endmodule

[src/ccgp_front.sv]
// Front end: accepts sample transactions and classifies group and genotype.
// Depends on ccgp_pkg and ccgp_in_if.
module ccgp_front
  import ccgp_pkg::*;
(
  ccgp_in_if.sink    samples,
  input  queue_stat_t qstat,
  output logic        push,
  output item_t       item
);

  assign samples.ready = !qstat.full;
  assign push          = samples.valid && !qstat.full;

  // Group codes two and three count as control; genotype codes above three are other called.
  always_comb begin
    item.counted  = (samples.sample_group != GRP_EXCLUDED) &&
                    (samples.genotype_code != GT_MISSING);
    item.is_class = (samples.genotype_code <= GT_HOM_ALT);
    item.cls      = samples.genotype_code[1:0];
    item.grp_ctrl = (samples.sample_group != GRP_CASE);
    item.last     = samples.last_of_site;
    item.tag      = samples.site_tag;
  end

endmodule

[src/ccgp_fifo.sv]
// Short queue of classified items between front and back.
// Depends on ccgp_pkg.
module ccgp_fifo
  import ccgp_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  item_t       push_item,
  input  logic        pop,
  output item_t       head,
  output queue_stat_t qstat
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  item_t            slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] fill;

  assign qstat.full  = (fill == CNT_W'(QUEUE_DEPTH));
  assign qstat.empty = (fill == '0);
  assign head        = slots[rd_ptr];

  function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wrap_inc(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= wrap_inc(rd_ptr);
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    qstat.full && !pop |-> !push) else $error("push into full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    qstat.empty |-> !pop) else $error("pop from empty queue");
  a_fill_tracks: assert property (@(posedge clk) disable iff (rst)
    push && !pop |=> fill == $past(fill) + 1'b1) else $error("fill count lost a push");
`endif

endmodule

[src/ccgp_back.sv]
// Back end: tallies classified items, then divides out six percentages per site.
// Depends on ccgp_pkg and ccgp_out_if.
module ccgp_back
  import ccgp_pkg::*;
#(
  parameter int MAX_SAMPLES = MAX_SAMPLES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  item_t       head,
  input  queue_stat_t qstat,
  output logic        pop,
  ccgp_out_if.source  results
);

  localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
  localparam int DW    = CNT_W + PCT_W;
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_SAMPLES);

  state_t state, state_next;

  logic [CNT_W-1:0] cls_cnt [PAIRS];
  logic [CNT_W-1:0] tot     [2];
  logic [PCT_W-1:0] pct     [PAIRS];
  logic [TAG_W-1:0] tag;
  logic [2:0]       pair;

  logic [DW-1:0]    rem;
  logic [CNT_W-1:0] dvs;
  logic [PCT_W-1:0] quo;
  logic [2:0]       step;
  logic             zero;

  logic             out_valid;
  logic [TAG_W-1:0] res_tag;
  logic [PCT_W-1:0] res_pct [PAIRS];

  logic             load_out;
  logic             clear;
  logic             div_last;

  logic [CNT_W-1:0] cnt_sel;
  logic [CNT_W-1:0] tot_sel;
  logic [DW-1:0]    shifted;
  logic             fits;
  logic [PCT_W-1:0] quo_next;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    return (v >= CNT_MAX) ? CNT_MAX : v + 1'b1;
  endfunction

  assign cnt_sel  = cls_cnt[pair];
  assign tot_sel  = tot[pair[0]];
  assign shifted  = DW'(dvs) << step;
  assign fits     = (rem >= shifted);
  assign div_last = (step == '0);

  always_comb begin
    quo_next = quo;
    if (fits) begin
      quo_next[step] = 1'b1;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_TALLY: if (!qstat.empty && head.last) state_next = ST_LOAD;
      ST_LOAD:  state_next = ST_DIV;
      ST_DIV: begin
        if (div_last) begin
          state_next = (pair == 3'(PAIRS - 1)) ? ST_OUT : ST_LOAD;
        end
      end
      ST_OUT:   if (load_out) state_next = ST_TALLY;
      default:  state_next = ST_TALLY;
    endcase
  end

  // outputs
  always_comb begin
    pop      = 1'b0;
    load_out = 1'b0;
    clear    = 1'b0;
    case (state)
      ST_TALLY: pop = !qstat.empty;
      ST_OUT: begin
        load_out = !out_valid || results.ready;
        clear    = load_out;
      end
      default: begin
        pop = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_TALLY;
    end else begin
      state <= state_next;
    end
  end

  // counters: each entry updates from its own value only
  always_ff @(posedge clk) begin
    if (rst || clear) begin
      for (int i = 0; i < PAIRS; i++) cls_cnt[i] <= '0;
      for (int g = 0; g < 2; g++) tot[g] <= '0;
    end else if (pop && head.counted) begin
      for (int i = 0; i < PAIRS; i++) begin
        if (head.is_class && (3'(i) == {head.cls, head.grp_ctrl})) begin
          cls_cnt[i] <= sat_inc(cls_cnt[i]);
        end
      end
      for (int g = 0; g < 2; g++) begin
        if (1'(g) == head.grp_ctrl) begin
          tot[g] <= sat_inc(tot[g]);
        end
      end
    end
  end

  // divider datapath: one quotient bit per cycle, quotient always below 128
  always_ff @(posedge clk) begin
    if (pop && head.last) begin
      tag <= head.tag;
    end
    case (state)
      ST_LOAD: begin
        rem  <= (DW'(cnt_sel) << 6) + (DW'(cnt_sel) << 5) + (DW'(cnt_sel) << 2);
        dvs  <= tot_sel;
        zero <= (tot_sel == '0);
        quo  <= '0;
        step <= 3'(PCT_W - 1);
      end
      ST_DIV: begin
        if (fits) begin
          rem <= rem - shifted;
        end
        quo <= quo_next;
        if (!div_last) begin
          step <= step - 1'b1;
        end else begin
          pct[pair] <= zero ? '0 : quo_next;
        end
      end
      default: begin
        quo <= quo;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pair <= '0;
    end else if (state == ST_TALLY) begin
      pair <= '0;
    end else if (state == ST_DIV && div_last) begin
      pair <= pair + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      res_tag <= tag;
      for (int i = 0; i < PAIRS; i++) res_pct[i] <= pct[i];
    end
  end

  assign results.valid               = out_valid;
  assign results.result_site_tag     = res_tag;
  assign results.case_hom_ref_pct    = res_pct[0];
  assign results.control_hom_ref_pct = res_pct[1];
  assign results.case_het_pct        = res_pct[2];
  assign results.control_het_pct     = res_pct[3];
  assign results.case_hom_alt_pct    = res_pct[4];
  assign results.control_hom_alt_pct = res_pct[5];

`ifndef SYNTHESIS
  a_total_covers_class: assert property (@(posedge clk) disable iff (rst)
    tot[0] >= cls_cnt[0] && tot[0] >= cls_cnt[2] && tot[0] >= cls_cnt[4] &&
    tot[1] >= cls_cnt[1] && tot[1] >= cls_cnt[3] && tot[1] >= cls_cnt[5])
    else $error("class count above its group total");
  a_saturated: assert property (@(posedge clk) disable iff (rst)
    tot[0] <= CNT_MAX && tot[1] <= CNT_MAX) else $error("group total past saturation");
  a_pct_range: assert property (@(posedge clk) disable iff (rst)
    state == ST_DIV && div_last && !zero |-> quo_next <= PCT_W'(100))
    else $error("percentage above one hundred");
  a_cleared: assert property (@(posedge clk) disable iff (rst)
    clear |=> tot[0] == '0 && tot[1] == '0) else $error("counters not cleared after result");
  a_no_pop_while_busy: assert property (@(posedge clk) disable iff (rst)
    state != ST_TALLY |-> !pop) else $error("item taken during division");
`endif

endmodule
